FILE: design/bomd_pkg.sv
// Shared types, codes and the UTF-8 encoder for the BOM detecting transcoder.
`default_nettype none

package bomd_pkg;

	// Input operation codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	// Encoding in effect for the stream
	typedef enum logic [1:0] {
		ENC_NONE = 2'd0,
		ENC_UTF8 = 2'd1,
		ENC_LE   = 2'd2,
		ENC_BE   = 2'd3
	} enc_t;

	// Error codes reported with a result
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_EOS   = 2'd1,
		ERR_TRAIL = 2'd2,
		ERR_RSVD  = 2'd3
	} err_t;

	// Lead-in detection phase
	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_ONE   = 2'd1,
		PH_EFBB  = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	localparam logic [7:0] BOM_FE = 8'hFE;
	localparam logic [7:0] BOM_FF = 8'hFF;
	localparam logic [7:0] BOM_EF = 8'hEF;
	localparam logic [7:0] BOM_BB = 8'hBB;
	localparam logic [7:0] BOM_BF = 8'hBF;

	localparam logic [5:0]  SURR_LEAD  = 6'b110110;
	localparam logic [5:0]  SURR_TRAIL = 6'b110111;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	localparam int unsigned MAX_RUN = 4;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] b;
	} utf8_t;

	// One result run: up to four entries, bytes go out from entry 0 upward.
	typedef struct packed {
		logic [2:0]      cnt;
		logic [3:0][7:0] bytes;
		logic [3:0]      has;
		err_t            err;
		enc_t            enc;
		logic            done;
	} run_t;

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.len  = 3'd1;
			r.b[0] = {1'b0, cp[6:0]};
		end else if (cp < 21'h800) begin
			r.len  = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.len  = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.len  = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/bom_detect_utf16_to_utf8.sv
// Top level of the byte order mark detecting UTF-16 to UTF-8 transcoder.
// The first result of an item goes through the input register and then the result register
// before it is on the outputs. Throughput: one item per cycle while each item gives at most
// one result and out_ready is high; an item that gives several results holds the result
// register until its last result is taken, and a next item that gives results waits in the
// input register meanwhile. Reset (arst_n low) clears detection, encoding, pending halves
// and both valid stages.
`default_nettype none

module bom_detect_utf16_to_utf8 (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       op,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic [1:0]      error_code,
	output logic [1:0]      detected_encoding,
	output logic            stream_done,
	output logic            last_of_run
);
	import bomd_pkg::*;

	// Input register
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// Stream state
	phase_t      phase_q, phase_d;
	enc_t        encoding_q, encoding_d;
	logic [7:0]  held0_q, held0_d;
	logic [7:0]  held1_q, held1_d;
	logic [7:0]  half_q, half_d;
	logic        half_valid_q, half_valid_d;
	logic [9:0]  hs_q, hs_d;
	logic        hs_valid_q, hs_valid_d;

	// Result register
	run_t       run_q, run_d;
	logic       run_valid_q;
	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic       at_last;
	logic       out_fire;
	logic       can_load;
	logic       adv_s1;

	logic [15:0] unit;
	logic [20:0] cp;
	utf8_t       enc8;

	assign last_idx = 2'(run_q.cnt - 3'd1);
	assign at_last  = (idx_q == last_idx);
	assign out_fire = run_valid_q && out_ready;
	assign can_load = !run_valid_q || (out_fire && at_last);
	assign adv_s1   = valid_s1 && ((run_d.cnt == 3'd0) || can_load);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			byte_s1 <= in_byte;
		end
	end

	// Code unit from the held half and the new byte; little endian puts the new byte on top.
	assign unit = (encoding_q == ENC_LE) ? {byte_s1, half_q} : {half_q, byte_s1};
	assign cp   = hs_valid_q ? ({1'b0, hs_q, unit[9:0]} + SUPP_BASE) : {5'd0, unit};
	assign enc8 = utf8_encode(cp);

	always_comb begin
		run_d        = '0;
		run_d.err    = ERR_NONE;
		run_d.enc    = encoding_q;
		phase_d      = phase_q;
		encoding_d   = encoding_q;
		held0_d      = held0_q;
		held1_d      = held1_q;
		half_d       = half_q;
		half_valid_d = half_valid_q;
		hs_d         = hs_q;
		hs_valid_d   = hs_valid_q;

		if (op_s1 == OP_EOS) begin
			// Held lead-in bytes are replayed ahead of the end-of-stream result.
			unique case (phase_q)
				PH_ONE: begin
					run_d.cnt      = 3'd2;
					run_d.bytes[0] = held0_q;
					run_d.has      = 4'b0001;
					run_d.enc      = ENC_NONE;
				end
				PH_EFBB: begin
					run_d.cnt      = 3'd3;
					run_d.bytes[0] = held0_q;
					run_d.bytes[1] = held1_q;
					run_d.has      = 4'b0011;
					run_d.enc      = ENC_NONE;
				end
				PH_DONE: begin
					run_d.cnt = 3'd1;
					if (half_valid_q || hs_valid_q) begin
						run_d.err = ERR_EOS;
					end
				end
				default: begin
					run_d.cnt = 3'd1;
				end
			endcase
			run_d.done   = 1'b1;
			phase_d      = PH_START;
			encoding_d   = ENC_NONE;
			half_valid_d = 1'b0;
			hs_valid_d   = 1'b0;
		end else begin
			unique case (phase_q)
				PH_START: begin
					held0_d = byte_s1;
					phase_d = PH_ONE;
				end
				PH_ONE: begin
					phase_d = PH_DONE;
					if (held0_q == BOM_FE && byte_s1 == BOM_FF) begin
						encoding_d = ENC_BE;
					end else if (held0_q == BOM_FF && byte_s1 == BOM_FE) begin
						encoding_d = ENC_LE;
					end else if (held0_q == BOM_EF && byte_s1 == BOM_BB) begin
						held1_d = byte_s1;
						phase_d = PH_EFBB;
					end else begin
						encoding_d     = ENC_NONE;
						run_d.enc      = ENC_NONE;
						run_d.cnt      = 3'd2;
						run_d.bytes[0] = held0_q;
						run_d.bytes[1] = byte_s1;
						run_d.has      = 4'b0011;
					end
				end
				PH_EFBB: begin
					phase_d = PH_DONE;
					if (byte_s1 == BOM_BF) begin
						encoding_d = ENC_UTF8;
					end else begin
						encoding_d     = ENC_NONE;
						run_d.enc      = ENC_NONE;
						run_d.cnt      = 3'd3;
						run_d.bytes[0] = held0_q;
						run_d.bytes[1] = held1_q;
						run_d.bytes[2] = byte_s1;
						run_d.has      = 4'b0111;
					end
				end
				default: begin
					if (encoding_q == ENC_LE || encoding_q == ENC_BE) begin
						if (!half_valid_q) begin
							half_d       = byte_s1;
							half_valid_d = 1'b1;
						end else begin
							half_valid_d = 1'b0;
							if (hs_valid_q && unit[15:10] != SURR_TRAIL) begin
								// A bad trail drops both the held lead and this unit.
								hs_valid_d = 1'b0;
								run_d.cnt  = 3'd1;
								run_d.err  = ERR_TRAIL;
							end else if (!hs_valid_q && unit[15:10] == SURR_LEAD) begin
								hs_d       = unit[9:0];
								hs_valid_d = 1'b1;
							end else begin
								hs_valid_d  = 1'b0;
								run_d.cnt   = enc8.len;
								run_d.bytes = enc8.b;
								run_d.has   = {enc8.len == 3'd4, enc8.len >= 3'd3,
									enc8.len >= 3'd2, enc8.len >= 3'd1};
							end
						end
					end else begin
						run_d.cnt      = 3'd1;
						run_d.bytes[0] = byte_s1;
						run_d.has      = 4'b0001;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			encoding_q   <= ENC_NONE;
			half_valid_q <= 1'b0;
			hs_valid_q   <= 1'b0;
		end else if (adv_s1) begin
			phase_q      <= phase_d;
			encoding_q   <= encoding_d;
			half_valid_q <= half_valid_d;
			hs_valid_q   <= hs_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			held0_q <= held0_d;
			held1_q <= held1_d;
			half_q  <= half_d;
			hs_q    <= hs_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (adv_s1 && run_d.cnt != 3'd0) begin
			run_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (out_fire) begin
			if (at_last) begin
				run_valid_q <= 1'b0;
			end
			idx_q <= 2'(idx_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && run_d.cnt != 3'd0) begin
			run_q <= run_d;
		end
	end

	assign out_valid         = run_valid_q;
	assign out_byte          = run_q.bytes[idx_q];
	assign has_byte          = run_q.has[idx_q];
	assign error_code        = at_last ? run_q.err : ERR_NONE;
	assign detected_encoding = run_q.enc;
	assign stream_done       = at_last && run_q.done;
	assign last_of_run       = at_last;

endmodule

`default_nettype wire

FILE: design/bomd_check.sv
// Port-level checker for the transcoder and its bind to the top level.
`default_nettype none

module bomd_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       has_byte,
	input wire logic [1:0] error_code,
	input wire logic       stream_done,
	input wire logic       last_of_run
);
	import bomd_pkg::*;

	// A stalled result must hold its byte.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("result changed while stalled");

	// End of stream always closes a run and carries no byte.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> last_of_run && !has_byte)
		else $error("stream_done not on a closing byteless result");

	// A result without a byte can only be the closing one of its run.
	a_nobyte_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> last_of_run)
		else $error("byteless result inside a run");

	// Truncation is reported only with end of stream; a bad trail never is.
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code == ERR_NONE)
			|| (error_code == ERR_EOS && stream_done)
			|| (error_code == ERR_TRAIL && !stream_done && !has_byte))
		else $error("error code inconsistent with result");

endmodule

bind bom_detect_utf16_to_utf8 bomd_check u_bomd_check (.*);

`default_nettype wire

FILE: test/bomd_stream_checker.sv
// Checker that predicts the UTF-8 results of the BOM detecting transcoder and compares them.
module bomd_stream_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic       op,
	input  wire logic [7:0] in_byte,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_byte,
	input  wire logic       has_byte,
	input  wire logic [1:0] error_code,
	input  wire logic [1:0] detected_encoding,
	input  wire logic       stream_done,
	input  wire logic       last_of_run,
	output int              fail_count,
	output int              due_count
);
	import bomd_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       has;
		err_t       err;
		enc_t       enc;
		logic       done;
		logic       last;
	} result_t;

	phase_t     lead_phase;
	enc_t       cur_enc;
	logic [7:0] lead0;
	logic [7:0] lead1;
	logic [7:0] half_byte;
	logic       half_ok;
	logic [9:0] high_bits;
	logic       high_ok;

	result_t    run_buf [4];
	int         run_cnt;
	result_t    due_results [$];

	task automatic clear_state();
		lead_phase = PH_START;
		cur_enc    = ENC_NONE;
		lead0      = '0;
		lead1      = '0;
		half_byte  = '0;
		half_ok    = 1'b0;
		high_bits  = '0;
		high_ok    = 1'b0;
	endtask

	task automatic add_result(input logic [7:0] b, input logic has, input err_t err,
			input logic done);
		run_buf[run_cnt] = '{b, has, err, cur_enc, done, 1'b0};
		run_cnt++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		add_result(b, 1'b1, ERR_NONE, 1'b0);
	endtask

	task automatic add_codepoint(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_byte(cp[7:0]);
		end else if (cp < 21'h800) begin
			add_byte(8'hC0 | 8'(cp >> 6));
			add_byte(8'h80 | 8'(cp & 21'h3F));
		end else if (cp < 21'h10000) begin
			add_byte(8'hE0 | 8'(cp >> 12));
			add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
			add_byte(8'h80 | 8'(cp & 21'h3F));
		end else begin
			add_byte(8'hF0 | 8'(cp >> 18));
			add_byte(8'h80 | 8'((cp >> 12) & 21'h3F));
			add_byte(8'h80 | 8'((cp >> 6) & 21'h3F));
			add_byte(8'h80 | 8'(cp & 21'h3F));
		end
	endtask

	task automatic utf16_byte(input logic [7:0] b);
		logic [15:0] unit;
		if (!half_ok) begin
			half_byte = b;
			half_ok   = 1'b1;
		end else begin
			half_ok = 1'b0;
			unit = (cur_enc == ENC_LE) ? {b, half_byte} : {half_byte, b};
			if (high_ok) begin
				// A pending high surrogate is dropped together with a bad partner.
				high_ok = 1'b0;
				if (unit[15:10] == SURR_TRAIL)
					add_codepoint(SUPP_BASE + {high_bits, unit[9:0]});
				else
					add_result(8'h00, 1'b0, ERR_TRAIL, 1'b0);
			end else if (unit[15:10] == SURR_LEAD) begin
				high_bits = unit[9:0];
				high_ok   = 1'b1;
			end else begin
				add_codepoint({5'b0, unit});
			end
		end
	endtask

	task automatic transcode_item(input logic o, input logic [7:0] b);
		err_t eos_err;
		run_cnt = 0;
		if (o == OP_EOS) begin
			eos_err = ERR_NONE;
			case (lead_phase)
				PH_ONE: begin
					cur_enc = ENC_NONE;
					add_byte(lead0);
				end
				PH_EFBB: begin
					cur_enc = ENC_NONE;
					add_byte(lead0);
					add_byte(lead1);
				end
				PH_DONE: begin
					if (half_ok || high_ok)
						eos_err = ERR_EOS;
				end
				default: ;
			endcase
			add_result(8'h00, 1'b0, eos_err, 1'b1);
			clear_state();
		end else begin
			case (lead_phase)
				PH_START: begin
					lead0      = b;
					lead_phase = PH_ONE;
				end
				PH_ONE: begin
					if (lead0 == BOM_FE && b == BOM_FF) begin
						cur_enc    = ENC_BE;
						lead_phase = PH_DONE;
					end else if (lead0 == BOM_FF && b == BOM_FE) begin
						cur_enc    = ENC_LE;
						lead_phase = PH_DONE;
					end else if (lead0 == BOM_EF && b == BOM_BB) begin
						lead1      = b;
						lead_phase = PH_EFBB;
					end else begin
						cur_enc    = ENC_NONE;
						lead_phase = PH_DONE;
						add_byte(lead0);
						add_byte(b);
					end
				end
				PH_EFBB: begin
					lead_phase = PH_DONE;
					if (b == BOM_BF) begin
						cur_enc = ENC_UTF8;
					end else begin
						cur_enc = ENC_NONE;
						add_byte(lead0);
						add_byte(lead1);
						add_byte(b);
					end
				end
				default: begin
					if (cur_enc == ENC_LE || cur_enc == ENC_BE)
						utf16_byte(b);
					else
						add_byte(b);
				end
			endcase
		end
		if (run_cnt > 0)
			run_buf[run_cnt - 1].last = 1'b1;
		for (int i = 0; i < run_cnt; i++)
			due_results.insert(due_results.size(), run_buf[i]);
	endtask

	task automatic report(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_result();
		result_t want;
		if (due_results.size() == 0) begin
			report($sformatf("unexpected result out_byte %h has_byte %b stream_done %b",
				out_byte, has_byte, stream_done));
		end else begin
			want = due_results[0];
			due_results.delete(0);
			if (out_byte !== want.b)
				report($sformatf("out_byte %h, expected %h", out_byte, want.b));
			if (has_byte !== want.has)
				report($sformatf("has_byte %b, expected %b", has_byte, want.has));
			if (error_code !== want.err)
				report($sformatf("error_code %0d, expected %0d", error_code, want.err));
			if (detected_encoding !== want.enc)
				report($sformatf("detected_encoding %0d, expected %0d",
					detected_encoding, want.enc));
			if (stream_done !== want.done)
				report($sformatf("stream_done %b, expected %b", stream_done, want.done));
			if (last_of_run !== want.last)
				report($sformatf("last_of_run %b, expected %b", last_of_run, want.last));
		end
	endtask

	// Results are checked before the item of the same edge is predicted; an item's
	// results never leave the block at the edge that accepts it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			due_results.delete();
			fail_count = 0;
			due_count <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				transcode_item(op, in_byte);
			due_count <= due_results.size();
		end
	end

endmodule

FILE: test/bom_detect_utf16_to_utf8_tb.sv
// Top of the transcoder testbench: clock, reset, byte stream stimulus and the verdict.
module bom_detect_utf16_to_utf8_tb;
	import bomd_pkg::*;

	localparam int IDLE_LIMIT  = 200;
	localparam int ITEM_TARGET = 165;
	localparam int EOS_MARK    = -1;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       op        = OP_DATA;
	logic [7:0] in_byte   = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       has_byte;
	logic [1:0] error_code;
	logic [1:0] detected_encoding;
	logic       stream_done;
	logic       last_of_run;

	int fail_count;
	int due_count;
	int items_sent     = 0;
	int stalled_cycles = 0;
	bit send_idle      = 1'b1;
	bit recv_idle      = 1'b1;
	bit little;
	int stream_q [$];

	bom_detect_utf16_to_utf8 u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.op                (op),
		.in_byte           (in_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_byte          (out_byte),
		.has_byte          (has_byte),
		.error_code        (error_code),
		.detected_encoding (detected_encoding),
		.stream_done       (stream_done),
		.last_of_run       (last_of_run)
	);

	bomd_stream_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.op                (op),
		.in_byte           (in_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_byte          (out_byte),
		.has_byte          (has_byte),
		.error_code        (error_code),
		.detected_encoding (detected_encoding),
		.stream_done       (stream_done),
		.last_of_run       (last_of_run),
		.fail_count        (fail_count),
		.due_count         (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Result side: a fresh stall is drawn for every result item.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = recv_idle ? $urandom_range(0, 15) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_item(input logic o, input logic [7:0] b);
		int gap;
		gap = send_idle ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_stream();
		foreach (stream_q[i]) begin
			if (stream_q[i] == EOS_MARK)
				send_item(OP_EOS, 8'($urandom));
			else
				send_item(OP_DATA, 8'(stream_q[i]));
		end
		stream_q.delete();
	endtask

	// Holds the sender off until the checker has nothing outstanding.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
	endtask

	task automatic stream_put(input int v);
		stream_q.insert(stream_q.size(), v);
	endtask

	task automatic put_unit(input logic [15:0] u);
		if (little) begin
			stream_put(u[7:0]);
			stream_put(u[15:8]);
		end else begin
			stream_put(u[15:8]);
			stream_put(u[7:0]);
		end
	endtask

	function automatic logic [9:0] pick10();
		case ($urandom_range(0, 3))
			0:       return 10'h000;
			1:       return 10'h3FF;
			default: return 10'($urandom);
		endcase
	endfunction

	task automatic put_random_bytes(input int n);
		repeat (n) stream_put($urandom_range(0, 255));
	endtask

	task automatic build_random_stream();
		int          kind;
		int          b;
		logic [15:0] u;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			little = (kind <= 2);
			put_unit(16'hFEFF);
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 9))
					0, 1: put_unit(16'($urandom_range(0, 'h7F)));
					2:    put_unit(16'($urandom_range('h80, 'h7FF)));
					3:    put_unit(16'($urandom_range('h800, 'hD7FF)));
					4:    put_unit(16'($urandom_range('hE000, 'hFFFF)));
					5, 6: begin
						put_unit({SURR_LEAD, pick10()});
						put_unit({SURR_TRAIL, pick10()});
					end
					7:    put_unit({SURR_TRAIL, pick10()});
					8: begin
						// High surrogate followed by anything but a trail surrogate.
						put_unit({SURR_LEAD, pick10()});
						u = 16'($urandom);
						if (u[15:10] == SURR_TRAIL)
							u[15] = 1'b0;
						put_unit(u);
					end
					default: put_unit(16'($urandom));
				endcase
			end
			case ($urandom_range(0, 9))
				0:       put_random_bytes(1);
				1:       put_unit({SURR_LEAD, pick10()});
				default: ;
			endcase
		end else if (kind == 6) begin
			stream_put(BOM_EF);
			stream_put(BOM_BB);
			stream_put(BOM_BF);
			put_random_bytes($urandom_range(0, 6));
		end else if (kind == 7) begin
			put_random_bytes($urandom_range(0, 8));
		end else if (kind == 8) begin
			stream_put(BOM_EF);
			case ($urandom_range(0, 3))
				0: begin
					stream_put(BOM_BB);
					b = $urandom_range(0, 255);
					stream_put(b == BOM_BF ? 0 : b);
				end
				1: begin
					b = $urandom_range(0, 255);
					stream_put(b == BOM_BB ? 0 : b);
				end
				2: stream_put(BOM_BB);
				default: ;
			endcase
			put_random_bytes($urandom_range(0, 4));
		end else begin
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 7) == 0)
					stream_put(EOS_MARK);
				else
					stream_put($urandom_range(0, 255));
			end
		end
		stream_put(EOS_MARK);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stream, a held EF BB lead-in flushed by end of stream, then a UTF-16LE
		// stream with a surrogate pair, a lone trail, a bad trail and a dangling half
		// unit, then UTF-16BE ending on a pending high surrogate.
		stream_q = '{EOS_MARK,
			'hEF, 'hBB, EOS_MARK,
			'hFF, 'hFE, 'h3D, 'hD8, 'h00, 'hDE, 'h00, 'hDC, 'h00, 'hD8, 'h41, 'h00,
			'h80, EOS_MARK,
			'hFE, 'hFF, 'h07, 'hFF, 'hD8, 'h00, EOS_MARK};
		send_stream();
		wait_for_results();

		while (items_sent < ITEM_TARGET) begin
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			build_random_stream();
			send_stream();
			if ($urandom_range(0, 9) == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
